>>> hdl/axis_angle_vector_rotator_assert.svh
// Assertion macros for the rotator RTL.
`ifndef AXIS_ANGLE_VECTOR_ROTATOR_ASSERT_SVH
`define AXIS_ANGLE_VECTOR_ROTATOR_ASSERT_SVH

// same-cycle implication
`define AAVR_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AAVR_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/aavr_pkg.sv
// Types, constants and tables for the axis-angle vector rotator.
package aavr_pkg;

  localparam int CW            = 24;
  localparam int TW            = 36;
  localparam int XW            = 34;
  localparam int CORDIC_STAGES = 20;
  localparam int SQ_STAGES     = 31;
  localparam int DIV_STAGES    = 31;
  localparam int SQ_BASE       = 5;
  localparam int PREP          = SQ_BASE + SQ_STAGES;
  localparam int DIV_BASE      = PREP + 1;
  localparam int FR_N          = DIV_BASE + DIV_STAGES;
  localparam int MX_N          = 6;
  localparam int ST_N          = FR_N + MX_N;

  localparam logic signed [TW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [TW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [TW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [XW-1:0] ONE_Q30     = 34'sd1073741824;

  typedef struct packed {
    logic [2:0][CW-1:0]     v;
    logic [2:0]             neg_a;
    logic [2:0][CW-1:0]     mag;
    logic [2:0][2*CW-2:0]   sq;
    logic signed [TW-1:0]   t;
    logic                   cneg;
    logic                   zero;
    logic [5:0]             h;
    logic [61:0]            n;
    logic [62:0]            r;
    logic signed [XW-1:0]   cx;
    logic signed [XW-1:0]   cy;
    logic [30:0]            s_root;
    logic [2:0][61:0]       d;
    logic [2:0][30:0]       rem;
    logic [2:0][30:0]       q;
  } fr_t;

  typedef struct packed {
    logic [2:0][CW-1:0]     v;
    logic                   zero;
    logic signed [31:0]     c;
    logic signed [31:0]     s;
    logic [2:0][31:0]       u;
    logic [5:0][63:0]       pp;
    logic [2:0][63:0]       qq;
    logic signed [32:0]     omc;
    logic [5:0][33:0]       tt;
    logic [2:0][33:0]       qr;
    logic [8:0][33:0]       m;
    logic [8:0][57:0]       prod;
    logic [2:0][CW-1:0]     rot;
    logic                   sat;
  } mx_t;

  function automatic logic signed [TW-1:0] atan_q30(input int i);
    logic signed [TW-1:0] val;
    begin
      unique case (i)
        0:  val = 36'sd843314857;
        1:  val = 36'sd497837829;
        2:  val = 36'sd263043837;
        3:  val = 36'sd133525159;
        4:  val = 36'sd67021687;
        5:  val = 36'sd33543516;
        6:  val = 36'sd16775851;
        7:  val = 36'sd8388437;
        8:  val = 36'sd4194283;
        9:  val = 36'sd2097149;
        10: val = 36'sd1048576;
        default: val = 36'sd1 <<< (30 - i);
      endcase
      return val;
    end
  endfunction

endpackage

>>> hdl/axis_angle_vector_rotator.sv
// Axis-angle vector rotator: fully pipelined Rodrigues rotation.
//
// Input channel: in_valid / in_stall with vec_*, axis_* (signed Q8.16) and
// angle (signed Q4.20 radians). A word is taken at an edge with in_valid
// high and in_stall low. Output channel: out_valid / out_stall with rot_*
// (signed Q8.16, saturated), axis_zero and saturated.
// Throughput is one word per cycle unless the output stalls. A taken word
// passes 74 registers: one input register, four stages of squaring, angle
// fold and normalization, 31 square-root stages (the CORDIC runs in the first
// 20 of them), one setup stage, 31 restoring-divide stages for the unit axis,
// then six matrix stages ending in the output register.
// The whole pipeline advances together; while out_valid is high and
// out_stall is asserted it freezes and in_stall is driven high, so no
// word is lost or repeated.
// Reset (rst, synchronous) clears all stage valid bits; no memory needs
// clearing.
`include "axis_angle_vector_rotator_assert.svh"

module axis_angle_vector_rotator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [aavr_pkg::CW-1:0]   vec_x,
  input  logic [aavr_pkg::CW-1:0]   vec_y,
  input  logic [aavr_pkg::CW-1:0]   vec_z,
  input  logic [aavr_pkg::CW-1:0]   axis_x,
  input  logic [aavr_pkg::CW-1:0]   axis_y,
  input  logic [aavr_pkg::CW-1:0]   axis_z,
  input  logic [23:0]               angle,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [aavr_pkg::CW-1:0]   rot_x,
  output logic [aavr_pkg::CW-1:0]   rot_y,
  output logic [aavr_pkg::CW-1:0]   rot_z,
  output logic                      axis_zero,
  output logic                      saturated
);

  aavr_pkg::fr_t fr    [aavr_pkg::FR_N];
  aavr_pkg::fr_t fr_nx [aavr_pkg::FR_N];
  aavr_pkg::mx_t mx    [aavr_pkg::MX_N];
  aavr_pkg::mx_t mx_nx [aavr_pkg::MX_N];
  logic [aavr_pkg::ST_N-1:0] vld;
  logic en;

  assign en        = !(vld[aavr_pkg::ST_N-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[aavr_pkg::ST_N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[aavr_pkg::ST_N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr <= fr_nx;
      mx <= mx_nx;
    end
  end

  // input capture
  logic [2:0][aavr_pkg::CW-1:0] ax_in;
  assign ax_in = {axis_z, axis_y, axis_x};

  always_comb begin
    fr_nx[0]   = '0;
    fr_nx[0].v = {vec_z, vec_y, vec_x};
    for (int i = 0; i < 3; i++) begin
      fr_nx[0].neg_a[i] = ax_in[i][aavr_pkg::CW-1];
      fr_nx[0].mag[i]   = ax_in[i][aavr_pkg::CW-1] ? (~ax_in[i] + 1'b1) : ax_in[i];
    end
    fr_nx[0].t = aavr_pkg::TW'($signed(angle)) <<< 10;
  end

  // squares and wrap into [-pi, pi]
  logic [2:0][2*aavr_pkg::CW-1:0] sq_full;
  always_comb begin
    fr_nx[1] = fr[0];
    for (int i = 0; i < 3; i++) begin
      sq_full[i]     = fr[0].mag[i] * fr[0].mag[i];
      fr_nx[1].sq[i] = sq_full[i][2*aavr_pkg::CW-2:0];
    end
    if (fr[0].t > aavr_pkg::PI_Q30) begin
      fr_nx[1].t = fr[0].t - aavr_pkg::TWO_PI_Q30;
    end else if (fr[0].t < -aavr_pkg::PI_Q30) begin
      fr_nx[1].t = fr[0].t + aavr_pkg::TWO_PI_Q30;
    end
  end

  // length squared, half-pi fold, CORDIC seed
  logic [2*aavr_pkg::CW-1:0] len2;
  always_comb begin
    fr_nx[2] = fr[1];
    len2 = {1'b0, fr[1].sq[0]} + {1'b0, fr[1].sq[1]} + {1'b0, fr[1].sq[2]};
    fr_nx[2].zero = (len2 == '0);
    fr_nx[2].n    = {len2, 14'b0};
    fr_nx[2].h    = 6'd7;
    fr_nx[2].cneg = 1'b0;
    fr_nx[2].cx   = aavr_pkg::GAIN_Q30;
    fr_nx[2].cy   = '0;
    if (fr[1].t > aavr_pkg::HALF_PI_Q30) begin
      fr_nx[2].t    = aavr_pkg::PI_Q30 - fr[1].t;
      fr_nx[2].cneg = 1'b1;
    end else if (fr[1].t < -aavr_pkg::HALF_PI_Q30) begin
      fr_nx[2].t    = -aavr_pkg::PI_Q30 - fr[1].t;
      fr_nx[2].cneg = 1'b1;
    end
  end

  // even-shift normalization, coarse
  always_comb begin
    fr_nx[3] = fr[2];
    if (fr_nx[3].n[61:30] == '0) begin
      fr_nx[3].n = {fr_nx[3].n[29:0], 32'b0};
      fr_nx[3].h = fr_nx[3].h + 6'd16;
    end
    if (fr_nx[3].n[61:46] == '0) begin
      fr_nx[3].n = {fr_nx[3].n[45:0], 16'b0};
      fr_nx[3].h = fr_nx[3].h + 6'd8;
    end
  end

  // even-shift normalization, fine
  always_comb begin
    fr_nx[4] = fr[3];
    if (fr_nx[4].n[61:54] == '0) begin
      fr_nx[4].n = {fr_nx[4].n[53:0], 8'b0};
      fr_nx[4].h = fr_nx[4].h + 6'd4;
    end
    if (fr_nx[4].n[61:58] == '0) begin
      fr_nx[4].n = {fr_nx[4].n[57:0], 4'b0};
      fr_nx[4].h = fr_nx[4].h + 6'd2;
    end
    if (fr_nx[4].n[61:60] == '0) begin
      fr_nx[4].n = {fr_nx[4].n[59:0], 2'b0};
      fr_nx[4].h = fr_nx[4].h + 6'd1;
    end
    fr_nx[4].r = '0;
  end

  // square root, one result bit per stage; CORDIC alongside
  for (genvar k = 0; k < aavr_pkg::SQ_STAGES; k++) begin : g_sqrt
    logic [63:0] sbit;
    logic [63:0] cmp;
    assign sbit = 64'd1 << (60 - 2 * k);
    assign cmp  = {1'b0, fr[aavr_pkg::SQ_BASE+k-1].r} + sbit;
    always_comb begin
      fr_nx[aavr_pkg::SQ_BASE+k] = fr[aavr_pkg::SQ_BASE+k-1];
      if ({2'b0, fr[aavr_pkg::SQ_BASE+k-1].n} >= cmp) begin
        fr_nx[aavr_pkg::SQ_BASE+k].n = 62'({2'b0, fr[aavr_pkg::SQ_BASE+k-1].n} - cmp);
        fr_nx[aavr_pkg::SQ_BASE+k].r =
          63'({1'b0, fr[aavr_pkg::SQ_BASE+k-1].r >> 1} + sbit);
      end else begin
        fr_nx[aavr_pkg::SQ_BASE+k].r = fr[aavr_pkg::SQ_BASE+k-1].r >> 1;
      end
      if (k < aavr_pkg::CORDIC_STAGES) begin
        if (fr[aavr_pkg::SQ_BASE+k-1].t >= 0) begin
          fr_nx[aavr_pkg::SQ_BASE+k].cx =
            fr[aavr_pkg::SQ_BASE+k-1].cx - (fr[aavr_pkg::SQ_BASE+k-1].cy >>> k);
          fr_nx[aavr_pkg::SQ_BASE+k].cy =
            fr[aavr_pkg::SQ_BASE+k-1].cy + (fr[aavr_pkg::SQ_BASE+k-1].cx >>> k);
          fr_nx[aavr_pkg::SQ_BASE+k].t =
            fr[aavr_pkg::SQ_BASE+k-1].t - aavr_pkg::atan_q30(k);
        end else begin
          fr_nx[aavr_pkg::SQ_BASE+k].cx =
            fr[aavr_pkg::SQ_BASE+k-1].cx + (fr[aavr_pkg::SQ_BASE+k-1].cy >>> k);
          fr_nx[aavr_pkg::SQ_BASE+k].cy =
            fr[aavr_pkg::SQ_BASE+k-1].cy - (fr[aavr_pkg::SQ_BASE+k-1].cx >>> k);
          fr_nx[aavr_pkg::SQ_BASE+k].t =
            fr[aavr_pkg::SQ_BASE+k-1].t + aavr_pkg::atan_q30(k);
        end
      end
    end
  end

  // divider setup, sine/cosine clip
  logic [6:0]             psh;
  logic [2:0][63:0]       dsh;
  logic signed [aavr_pkg::XW-1:0] cclip;
  always_comb begin
    fr_nx[aavr_pkg::PREP]        = fr[aavr_pkg::PREP-1];
    fr_nx[aavr_pkg::PREP].s_root = fr[aavr_pkg::PREP-1].r[30:0];
    psh = 7'd30 + {1'b0, fr[aavr_pkg::PREP-1].h};
    for (int i = 0; i < 3; i++) begin
      dsh[i] = 64'(fr[aavr_pkg::PREP-1].mag[i]) << psh;
      fr_nx[aavr_pkg::PREP].d[i]   = dsh[i][61:0] + 62'(fr[aavr_pkg::PREP-1].r[30:1]);
      fr_nx[aavr_pkg::PREP].rem[i] = fr_nx[aavr_pkg::PREP].d[i][61:31];
    end
    if (fr[aavr_pkg::PREP-1].cx > aavr_pkg::ONE_Q30) begin
      cclip = aavr_pkg::ONE_Q30;
    end else if (fr[aavr_pkg::PREP-1].cx < -aavr_pkg::ONE_Q30) begin
      cclip = -aavr_pkg::ONE_Q30;
    end else begin
      cclip = fr[aavr_pkg::PREP-1].cx;
    end
    fr_nx[aavr_pkg::PREP].cx = fr[aavr_pkg::PREP-1].cneg ? -cclip : cclip;
    if (fr[aavr_pkg::PREP-1].cy > aavr_pkg::ONE_Q30) begin
      fr_nx[aavr_pkg::PREP].cy = aavr_pkg::ONE_Q30;
    end else if (fr[aavr_pkg::PREP-1].cy < -aavr_pkg::ONE_Q30) begin
      fr_nx[aavr_pkg::PREP].cy = -aavr_pkg::ONE_Q30;
    end
  end

  // restoring divide, one quotient bit per stage, three lanes
  for (genvar j = 0; j < aavr_pkg::DIV_STAGES; j++) begin : g_div
    localparam int B = aavr_pkg::DIV_STAGES - 1 - j;
    logic [2:0][31:0] r2;
    always_comb begin
      fr_nx[aavr_pkg::DIV_BASE+j] = fr[aavr_pkg::DIV_BASE+j-1];
      for (int i = 0; i < 3; i++) begin
        r2[i] = {fr[aavr_pkg::DIV_BASE+j-1].rem[i], fr[aavr_pkg::DIV_BASE+j-1].d[i][B]};
        if (r2[i] >= {1'b0, fr[aavr_pkg::DIV_BASE+j-1].s_root}) begin
          fr_nx[aavr_pkg::DIV_BASE+j].rem[i] =
            31'(r2[i] - {1'b0, fr[aavr_pkg::DIV_BASE+j-1].s_root});
          fr_nx[aavr_pkg::DIV_BASE+j].q[i][B] = 1'b1;
        end else begin
          fr_nx[aavr_pkg::DIV_BASE+j].rem[i]  = r2[i][30:0];
          fr_nx[aavr_pkg::DIV_BASE+j].q[i][B] = 1'b0;
        end
      end
    end
  end

  // unit axis with sign, hand-off to matrix stages
  logic [2:0][31:0] uq;
  always_comb begin
    mx_nx[0]      = '0;
    mx_nx[0].v    = fr[aavr_pkg::FR_N-1].v;
    mx_nx[0].zero = fr[aavr_pkg::FR_N-1].zero;
    mx_nx[0].c    = 32'(fr[aavr_pkg::FR_N-1].cx);
    mx_nx[0].s    = 32'(fr[aavr_pkg::FR_N-1].cy);
    for (int i = 0; i < 3; i++) begin
      uq[i] = (fr[aavr_pkg::FR_N-1].q[i] > 31'h4000_0000) ? 32'h4000_0000
                                                          : {1'b0, fr[aavr_pkg::FR_N-1].q[i]};
      if (fr[aavr_pkg::FR_N-1].zero) begin
        mx_nx[0].u[i] = '0;
      end else begin
        mx_nx[0].u[i] = fr[aavr_pkg::FR_N-1].neg_a[i] ? -uq[i] : uq[i];
      end
    end
  end

  // outer products u_i*u_j and u_k*s
  always_comb begin
    mx_nx[1]       = mx[0];
    mx_nx[1].pp[0] = 64'($signed(mx[0].u[0]) * $signed(mx[0].u[0]));
    mx_nx[1].pp[1] = 64'($signed(mx[0].u[0]) * $signed(mx[0].u[1]));
    mx_nx[1].pp[2] = 64'($signed(mx[0].u[0]) * $signed(mx[0].u[2]));
    mx_nx[1].pp[3] = 64'($signed(mx[0].u[1]) * $signed(mx[0].u[1]));
    mx_nx[1].pp[4] = 64'($signed(mx[0].u[1]) * $signed(mx[0].u[2]));
    mx_nx[1].pp[5] = 64'($signed(mx[0].u[2]) * $signed(mx[0].u[2]));
    for (int i = 0; i < 3; i++) begin
      mx_nx[1].qq[i] = 64'($signed(mx[0].u[i]) * mx[0].s);
    end
    mx_nx[1].omc = 33'sh0_4000_0000 - 33'(mx[0].c);
  end

  // scale by (1 - c)
  logic signed [63:0] pr  [6];
  logic signed [31:0] prs [6];
  logic signed [65:0] tp  [6];
  logic signed [63:0] qsh [3];
  always_comb begin
    mx_nx[2] = mx[1];
    for (int p = 0; p < 6; p++) begin
      pr[p]  = ($signed(mx[1].pp[p]) + 64'sd536870912) >>> 30;
      prs[p] = pr[p][31:0];
      tp[p]  = 66'(prs[p] * mx[1].omc);
      tp[p]  = (tp[p] + 66'sd536870912) >>> 30;
      mx_nx[2].tt[p] = tp[p][33:0];
    end
    for (int i = 0; i < 3; i++) begin
      qsh[i] = ($signed(mx[1].qq[i]) + 64'sd536870912) >>> 30;
      mx_nx[2].qr[i] = qsh[i][33:0];
    end
  end

  // assemble rotation matrix, round to Q28
  logic signed [35:0] mf [9];
  logic signed [35:0] tx [6];
  logic signed [35:0] qx [3];
  logic signed [35:0] cxm;
  always_comb begin
    mx_nx[3] = mx[2];
    for (int p = 0; p < 6; p++) begin
      tx[p] = 36'($signed(mx[2].tt[p]));
    end
    for (int i = 0; i < 3; i++) begin
      qx[i] = 36'($signed(mx[2].qr[i]));
    end
    cxm   = 36'(mx[2].c);
    mf[0] = tx[0] + cxm;
    mf[1] = tx[1] - qx[2];
    mf[2] = tx[2] + qx[1];
    mf[3] = tx[1] + qx[2];
    mf[4] = tx[3] + cxm;
    mf[5] = tx[4] - qx[0];
    mf[6] = tx[2] - qx[1];
    mf[7] = tx[4] + qx[0];
    mf[8] = tx[5] + cxm;
    for (int e = 0; e < 9; e++) begin
      mf[e] = (mf[e] + 36'sd2) >>> 2;
      mx_nx[3].m[e] = mf[e][33:0];
    end
  end

  // matrix times vector, per entry
  always_comb begin
    mx_nx[4] = mx[3];
    for (int e = 0; e < 9; e++) begin
      mx_nx[4].prod[e] = 58'($signed(mx[3].m[e]) * $signed(mx[3].v[e % 3]));
    end
  end

  // row sums, round, saturate
  logic signed [59:0] acc [3];
  logic signed [31:0] res [3];
  localparam logic signed [31:0] RES_HI = 32'sd2 ** (aavr_pkg::CW - 1) - 32'sd1;
  localparam logic signed [31:0] RES_LO = -(32'sd2 ** (aavr_pkg::CW - 1));
  always_comb begin
    mx_nx[5]     = mx[4];
    mx_nx[5].sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc[i] = 60'($signed(mx[4].prod[3*i])) + 60'($signed(mx[4].prod[3*i+1]))
             + 60'($signed(mx[4].prod[3*i+2]));
      acc[i] = (acc[i] + 60'sd134217728) >>> 28;
      res[i] = acc[i][31:0];
      if (res[i] > RES_HI) begin
        res[i] = RES_HI;
        mx_nx[5].sat = 1'b1;
      end else if (res[i] < RES_LO) begin
        res[i] = RES_LO;
        mx_nx[5].sat = 1'b1;
      end
      mx_nx[5].rot[i] = res[i][aavr_pkg::CW-1:0];
    end
  end

  assign rot_x     = mx[aavr_pkg::MX_N-1].rot[0];
  assign rot_y     = mx[aavr_pkg::MX_N-1].rot[1];
  assign rot_z     = mx[aavr_pkg::MX_N-1].rot[2];
  assign axis_zero = mx[aavr_pkg::MX_N-1].zero;
  assign saturated = mx[aavr_pkg::MX_N-1].sat;

  `AAVR_CHECK(a_norm_range, vld[4] && !fr[4].zero, fr[4].n[61:60] != 2'b00,
              "norm shift short")
  `AAVR_CHECK(a_root_msb, vld[aavr_pkg::PREP] && !fr[aavr_pkg::PREP].zero,
              fr[aavr_pkg::PREP].s_root[30], "root below range")
  `AAVR_CHECK(a_fold, vld[2],
              (fr[2].t <= aavr_pkg::HALF_PI_Q30) && (fr[2].t >= -aavr_pkg::HALF_PI_Q30),
              "angle fold out of range")
  `AAVR_NEXT(a_flow, en && vld[aavr_pkg::ST_N-2], vld[aavr_pkg::ST_N-1], "word dropped at output")

endmodule

>>> bench/tb.sv
// Self-checking bench for the axis-angle rotator: Rodrigues predictor and scoreboard.
`timescale 1ns / 1ps

module tb;

  localparam int  N_RANDOM   = 830;
  localparam int  IDLE_LIMIT = 4000;
  localparam int  HOLD_LEN   = 300;
  localparam longint ONE     = 64'sd1 << 30;
  localparam longint PI_V    = 64'sd3373259426;
  localparam longint HPI_V   = 64'sd1686629713;
  localparam longint GAIN_V  = 64'sd652032874;

  typedef struct {
    logic [aavr_pkg::CW-1:0] v[3];
    logic [aavr_pkg::CW-1:0] a[3];
    logic [23:0]   ang;
  } rot_req_t;

  typedef struct {
    logic [aavr_pkg::CW-1:0] r[3];
    logic          zero;
    logic          sat;
  } rot_res_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [aavr_pkg::CW-1:0] vec_x = 0, vec_y = 0, vec_z = 0;
  logic [aavr_pkg::CW-1:0] axis_x = 0, axis_y = 0, axis_z = 0;
  logic [23:0] angle = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [aavr_pkg::CW-1:0] rot_x, rot_y, rot_z;
  logic axis_zero, saturated;

  rot_req_t pending[$];
  rot_res_t expected_rot[$];
  rot_req_t cur;
  longint atan_q[30];
  int errors = 0, sent = 0, got = 0, zero_seen = 0, sat_seen = 0;
  int gap = 0, burst = 0, stall_cnt = 0, hold_cnt = 0, idle = 0;
  bit held = 0;

  always #2 clk = ~clk;

  axis_angle_vector_rotator dut (.*);

  function automatic longint rnd(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip1(longint x);
    if (x > ONE) return ONE;
    if (x < -ONE) return -ONE;
    return x;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic rot_res_t rotate(rot_req_t q);
    rot_res_t o;
    longint v[3], a[3], u[3], m[3][3];
    longint t, x, y, nx, c, s, omc, acc, res, qv;
    longint unsigned len2, sq, mag, num, quo;
    int h;
    bit neg;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(q.v[i]));
      a[i] = longint'($signed(q.a[i]));
    end
    len2 = 0;
    for (int i = 0; i < 3; i++) len2 += longint'(a[i] * a[i]);
    o.zero = (len2 == 0);
    h = 0;
    if (o.zero) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
    end else begin
      if (len2 >= (64'd1 << 62)) begin
        len2 >>= 2; h = -1;
      end else while (len2 < (64'd1 << 60)) begin
        len2 <<= 2; h++;
      end
      sq = root64(len2);
      for (int i = 0; i < 3; i++) begin
        mag = (a[i] < 0) ? -a[i] : a[i];
        num = (h >= 0) ? (mag << (30 + h)) : (mag << 29);
        quo = (num + sq / 2) / sq;
        if (quo > ONE) quo = ONE;
        u[i] = (a[i] < 0) ? -longint'(quo) : longint'(quo);
      end
    end
    t = longint'($signed(q.ang)) * 1024;
    while (t > PI_V) t -= 2 * PI_V;
    while (t < -PI_V) t += 2 * PI_V;
    neg = 0;
    if (t > HPI_V) begin t = PI_V - t; neg = 1; end
    else if (t < -HPI_V) begin t = -PI_V - t; neg = 1; end
    x = GAIN_V; y = 0;
    for (int i = 0; i < aavr_pkg::CORDIC_STAGES; i++) begin
      if (t >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); t -= atan_q[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); t += atan_q[i];
      end
      x = nx;
    end
    x = clip1(x);
    c = neg ? -x : x;
    s = clip1(y);
    omc = ONE - c;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = rnd(rnd(u[i] * u[j], 30) * omc, 30);
    for (int i = 0; i < 3; i++) begin
      qv = rnd(u[i] * s, 30);
      m[i][i] += c;
      m[(i + 2) % 3][(i + 1) % 3] += qv;
      m[(i + 1) % 3][(i + 2) % 3] -= qv;
    end
    o.sat = 0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += rnd(m[i][j], 2) * v[j];
      res = rnd(acc, 28);
      if (res > 64'sd8388607) begin res = 64'sd8388607; o.sat = 1; end
      if (res < -64'sd8388608) begin res = -64'sd8388608; o.sat = 1; end
      o.r[i] = res[aavr_pkg::CW-1:0];
    end
    return o;
  endfunction

  function automatic rot_req_t mk(int vx, int vy, int vz, int ax, int ay, int az, int an);
    rot_req_t q;
    q.v[0] = aavr_pkg::CW'(vx); q.v[1] = aavr_pkg::CW'(vy); q.v[2] = aavr_pkg::CW'(vz);
    q.a[0] = aavr_pkg::CW'(ax); q.a[1] = aavr_pkg::CW'(ay); q.a[2] = aavr_pkg::CW'(az);
    q.ang = 24'(an);
    return q;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_rot.push_back(rotate(cur));
        sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 0;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          vec_x <= cur.v[0]; vec_y <= cur.v[1]; vec_z <= cur.v[2];
          axis_x <= cur.a[0]; axis_y <= cur.a[1]; axis_z <= cur.a[2];
          angle <= cur.ang;
          in_valid <= 1;
          if (burst > 0) begin burst--; gap = 0; end
          else begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 30) == 0) burst = $urandom_range(20, 60);
          end
        end else in_valid <= 0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (!held && sent >= 300) begin
        held <= 1;
        hold_cnt <= HOLD_LEN;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rot_res_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got++;
        if (expected_rot.size() == 0) begin
          $error("unexpected output word");
          errors++;
        end else begin
          e = expected_rot.pop_front();
          if (rot_x !== e.r[0]) begin $error("rot_x exp %h got %h", e.r[0], rot_x); errors++; end
          if (rot_y !== e.r[1]) begin $error("rot_y exp %h got %h", e.r[1], rot_y); errors++; end
          if (rot_z !== e.r[2]) begin $error("rot_z exp %h got %h", e.r[2], rot_z); errors++; end
          if (axis_zero !== e.zero) begin
            $error("axis_zero exp %b got %b", e.zero, axis_zero); errors++;
          end
          if (saturated !== e.sat) begin
            $error("saturated exp %b got %b", e.sat, saturated); errors++;
          end
          zero_seen += e.zero;
          sat_seen += e.sat;
        end
        stall_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
      if (hold_cnt > 0) begin
        out_stall <= 1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall <= 1;
      end else out_stall <= 0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle <= 0;
    else if (idle >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else idle <= idle + 1;
  end

  initial begin
    longint sum, term;
    int e, sh;
    rot_req_t q;
    atan_q[0] = 64'sd843314857;
    for (int i = 1; i < 30; i++) begin
      sum = 0;
      for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
        e = 62 - i * (2 * k + 1);
        term = longint'((64'd1 << e) / (2 * k + 1));
        sum += (k & 1) ? -term : term;
      end
      atan_q[i] = rnd(sum, 32);
    end

    pending.push_back(mk(65536, 131072, -65536, 0, 0, 0, 1048576));
    pending.push_back(mk(65536, 0, 0, 0, 0, 65536, 1647099));
    pending.push_back(mk(65536, 0, 0, 0, 0, 65536, -1647099));
    pending.push_back(mk(0, 65536, 0, 65536, 0, 0, 3294199));
    pending.push_back(mk(0, 0, 65536, 0, 65536, 0, -3294199));
    pending.push_back(mk(65536, 65536, 65536, 1, 1, 1, 0));
    pending.push_back(mk(8388607, 8388607, 0, 0, 0, 65536, 823550));
    pending.push_back(mk(-8388608, -8388608, -8388608, 0, 0, 65536, -823550));
    pending.push_back(mk(8388607, -8388608, 8388607, 8388607, 8388607, 8388607, 8388607));
    pending.push_back(mk(-8388608, 8388607, -8388608, -8388608, -8388608, -8388608, -8388608));
    pending.push_back(mk(8388607, 8388607, 8388607, 0, 0, 0, -8388608));
    pending.push_back(mk(-8388608, 0, 8388607, 1, 0, 0, 8388607));
    pending.push_back(mk(12345, -6789, 424242, -8388608, 0, 1, 6588398));
    pending.push_back(mk(100000, 200000, 300000, 3, -4, 12, -6588398));
    pending.push_back(mk(-1, 1, -1, 0, -1, 0, 1));
    pending.push_back(mk(500000, -500000, 0, 65536, 65536, 0, -1));
    pending.push_back(mk(8388607, 8388607, 8388607, 65536, -65536, 65536, 2196132));
    pending.push_back(mk(0, 0, 0, 777, 888, 999, 4000000));
    for (int n = 0; n < N_RANDOM; n++) begin
      for (int i = 0; i < 3; i++) q.v[i] = aavr_pkg::CW'($urandom);
      sh = $urandom_range(0, 22);
      for (int i = 0; i < 3; i++) begin
        q.a[i] = aavr_pkg::CW'($urandom);
        if ($urandom_range(0, 1)) q.a[i] = $signed(q.a[i]) >>> sh;
      end
      if ($urandom_range(0, 19) == 0) begin q.a[0] = 0; q.a[1] = 0; q.a[2] = 0; end
      else if ($urandom_range(0, 9) == 0) q.a[$urandom_range(0, 2)] = 0;
      q.ang = 24'($urandom);
      if ($urandom_range(0, 9) == 0) q.ang = $signed(q.ang) >>> $urandom_range(1, 20);
      pending.push_back(q);
    end

    repeat (12) @(posedge clk);
    rst <= 0;
    while (pending.size() > 0 || in_valid || expected_rot.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Rotated %0d words, %0d checked; %0d zero-axis and %0d saturating results.",
             sent, got, zero_seen, sat_seen);
    if (errors == 0 && expected_rot.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/aavr_pkg.sv
hdl/axis_angle_vector_rotator.sv
bench/tb.sv
